[hdl/scc_pkg.sv]
// Shared types and constants for the sprite column command generator.
// Used by scc_input_stage, scc_column_core and the top level; depends on nothing.
`default_nettype none

package scc_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned POS_X_W  = 9;
  localparam int unsigned POS_Y_W  = 10;
  localparam int unsigned TILE_W   = 15;
  localparam int unsigned COLOUR_W = 7;
  localparam int unsigned CMD_W    = POS_X_W + POS_Y_W + TILE_W + COLOUR_W + 2;
  localparam int unsigned OUT_TDATA_W = ((CMD_W + 7) / 8) * 8;

  localparam logic ACTION_HEADER = 1'b0;
  localparam logic ACTION_ENTRY  = 1'b1;

  localparam logic CFG_LAYOUT_MODE = 1'b0;
  localparam logic CFG_FLIP_SELECT = 1'b1;

  localparam logic [TILE_W-1:0]    TILE_LIMIT = 15'h5fff;
  localparam logic [POS_Y_W:0]     Y_STEP     = 11'd16;
  localparam logic [POS_Y_W:0]     Y_SPAN     = 11'd512;
  localparam logic signed [POS_Y_W:0] Y_MAX   = 11'sd256;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } item_t;

  typedef struct packed {
    logic                flip_y;
    logic                flip_x;
    logic [COLOUR_W-1:0] colour_code;
    logic [TILE_W-1:0]   tile_code;
    logic [POS_Y_W-1:0]  pos_y;
    logic [POS_X_W-1:0]  pos_x;
  } cmd_t;

  typedef struct packed {
    logic layout_mode;
    logic flip_vertical_select;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/scc_input_stage.sv]
// Input register of the sprite column command generator.
// Holds one accepted beat until the core takes it; depends on scc_pkg.
`default_nettype none

module scc_input_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire scc_pkg::item_t in_item,
  output logic               held_valid,
  output scc_pkg::item_t     held_item,
  input  wire logic          take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

[hdl/scc_column_core.sv]
// Column state, command decode and result register of the sprite column
// command generator. Depends on scc_pkg.
`default_nettype none

module scc_column_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire scc_pkg::cfg_t  cfg,
  input  wire logic           held_valid,
  input  wire scc_pkg::item_t held_item,
  output logic                take,
  output logic                out_valid,
  input  wire logic           out_ready,
  output scc_pkg::cmd_t       out_cmd
);

  logic [scc_pkg::POS_X_W-1:0] column_x;
  logic [scc_pkg::POS_Y_W-1:0] column_y;
  logic                        column_stopped;

  logic [scc_pkg::POS_X_W-1:0] column_x_next;
  logic [scc_pkg::POS_Y_W-1:0] column_y_next;
  logic                        column_stopped_next;

  logic                          fire;
  logic                          is_entry;
  logic [scc_pkg::COLOUR_W-1:0]  colour;
  logic [scc_pkg::TILE_W-1:0]    tile;
  logic                          fx;
  logic                          fy;
  logic                          colour_nz;
  logic                          limit_hit;
  logic                          issue;
  logic                          advance;
  logic [scc_pkg::POS_Y_W:0]     y_sum;
  logic [scc_pkg::POS_Y_W-1:0]   y_stepped;
  logic [scc_pkg::POS_Y_W-1:0]   y_header;
  scc_pkg::cmd_t                 cmd;

  assign take     = held_valid && (!out_valid || out_ready);
  assign fire     = take;
  assign is_entry = held_item.action == scc_pkg::ACTION_ENTRY;

  always_comb begin
    colour    = held_item.first_word[scc_pkg::COLOUR_W-1:0];
    colour_nz = colour != '0;
    if (!cfg.layout_mode) begin
      fy   = held_item.second_word[15];
      fx   = held_item.second_word[14];
      tile = {1'b0, held_item.second_word[13:0]};
    end else begin
      tile = held_item.second_word[scc_pkg::TILE_W-1:0];
      fy   = cfg.flip_vertical_select ? held_item.second_word[15] : 1'b0;
      fx   = cfg.flip_vertical_select ? 1'b0 : held_item.second_word[15];
    end
    limit_hit = cfg.layout_mode && colour_nz && (tile > scc_pkg::TILE_LIMIT);
    issue     = is_entry && !column_stopped && colour_nz && !limit_hit;
    advance   = is_entry && !column_stopped && !limit_hit;

    y_sum = {column_y[scc_pkg::POS_Y_W-1], column_y} + scc_pkg::Y_STEP;
    if ($signed(y_sum) > scc_pkg::Y_MAX) begin
      y_sum = y_sum - scc_pkg::Y_SPAN;
    end
    y_stepped = y_sum[scc_pkg::POS_Y_W-1:0];
    y_header  = 10'd0 - {held_item.second_word[8], held_item.second_word[8:0]};

    column_x_next       = column_x;
    column_y_next       = column_y;
    column_stopped_next = column_stopped;
    if (!is_entry) begin
      column_x_next       = {held_item.first_word[4:0], held_item.second_word[15:12]};
      column_y_next       = y_header;
      column_stopped_next = 1'b0;
    end else if (advance) begin
      column_y_next = y_stepped;
    end else if (limit_hit && !column_stopped) begin
      column_stopped_next = 1'b1;
    end

    cmd.pos_x       = column_x;
    cmd.pos_y       = column_y;
    cmd.tile_code   = tile;
    cmd.colour_code = colour;
    cmd.flip_x      = fx;
    cmd.flip_y      = fy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_x       <= '0;
      column_y       <= '0;
      column_stopped <= 1'b0;
      out_valid      <= 1'b0;
    end else if (fire) begin
      column_x       <= column_x_next;
      column_y       <= column_y_next;
      column_stopped <= column_stopped_next;
      out_valid      <= issue;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && issue) begin
      out_cmd <= cmd;
    end
  end

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && is_entry && column_stopped) |=> !out_valid)
    else $error("A stopped column produced a command.");

  a_colour_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cmd.colour_code != '0))
    else $error("A command carries a zero colour.");

  a_y_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(column_y) >= -10'sd255) && ($signed(column_y) <= 10'sd256))
    else $error("Column y left its wrap range.");

  a_header_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_entry) |=> !column_stopped)
    else $error("A header did not restart the column.");

endmodule

`default_nettype wire

[hdl/sprite_column_command_generator.sv]
// Top level of the sprite column command generator: input register, column core.
// Depends on scc_pkg, scc_input_stage and scc_column_core.
// An entry beat is held in the input register, then its command in the core's result register.
// Throughput: one input beat per cycle while m_tready does not stall the output, set by the single decode stage.
// Reset clears the column position, the stop flag, the configuration and all valids, not the data registers.
`default_nettype none

module sprite_column_command_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // first_word[15:0], second_word[31:16]
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [scc_pkg::OUT_TDATA_W-1:0] m_tdata,
  // pos_x[8:0], pos_y[18:9], tile_code[33:19], colour_code[40:34],
  // flip_x[41], flip_y[42], zero fill above
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  scc_pkg::item_t in_item;
  scc_pkg::item_t held_item;
  scc_pkg::cmd_t  out_cmd;
  scc_pkg::cfg_t  cfg;
  logic           held_valid;
  logic           take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scc_pkg::CFG_LAYOUT_MODE: cfg.layout_mode          <= cfg_data;
        scc_pkg::CFG_FLIP_SELECT: cfg.flip_vertical_select <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  assign in_item.action      = s_tuser;
  assign in_item.first_word  = s_tdata[15:0];
  assign in_item.second_word = s_tdata[31:16];

  scc_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  scc_column_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_cmd    (out_cmd)
  );

  assign m_tdata = {{(scc_pkg::OUT_TDATA_W - scc_pkg::CMD_W){1'b0}}, out_cmd};

endmodule

`default_nettype wire
